// ===== rtl/core/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and constants shared by the buddy frame allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  localparam int MAX_ORDER = 10;
  localparam int FRAME_W   = MAX_ORDER;
  localparam int NFRAMES   = 1 << FRAME_W;
  localparam int LINK_W    = FRAME_W + 1;
  localparam int ORD_W     = 4;

  // A link with its top bit set points nowhere.
  localparam logic [LINK_W-1:0] NIL      = LINK_W'(NFRAMES);
  localparam logic [ORD_W-1:0]  ORD_NONE = '1;
  localparam logic [ORD_W-1:0]  ORD_MAX  = ORD_W'(MAX_ORDER);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [ORD_W-1:0]   order;
    logic [FRAME_W-1:0] frame_index;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] block_index;
  } rsp_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SPLIT_RD,
    CMD_SPLIT_W1,
    CMD_SPLIT_W2,
    CMD_SPLIT_W3,
    CMD_POP_RD,
    CMD_POP_WR,
    CMD_FREE_RD,
    CMD_FREE_TST,
    CMD_BUD_RD,
    CMD_UNLINK,
    CMD_MERGE_W2,
    CMD_PUSH1,
    CMD_PUSH2,
    CMD_RESULT
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic alloc_fail;
    logic e_eq_k;
    logic e_next_k;
    logic free_bad;
    logic free_top;
    logic bud_ok;
    logic o_next_top;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bfa_chan_if.sv =====
// ----------------------------------------------------------------------------
// bfa_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfa_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/buddy_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_frame_allocator
// Buddy allocator over 1024 frames with one LIFO free list per order.
//
// Requests arrive as beats on req: operation 0 allocates a block of the
// given order, operation 1 frees the block headed by frame_index. Each
// request yields exactly one beat on rsp carrying ok and block_index.
// One request is worked on at a time; req.ready is high only while idle.
// An allocate splits a larger free block once per order above the
// requested one (up to 10 splits); a free merges with its buddy while
// the buddy is free at the same order, stopping at the top order.
// Each split or merge step is a few single-port accesses to the frame
// order, free flag and link tables.
// After reset a clearing pass writes the entry of every frame in the frame
// tables, and no request is accepted until it has finished.
// The result sits in an output register; if the receiver stalls, the
// next request is still accepted and worked on, and its result waits
// until the previous beat has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_frame_allocator
  import bfa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  bfa_chan_if.sink        req,
  bfa_chan_if.source      rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       ready;

  assign req.ready = ready;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ready),
    .status   (status),
    .cmd      (cmd)
  );

  bfa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_data  (req.data),
    .rsp_data  (rsp.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
  );

  // The clearing pass keeps requests out right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !ready)
    else $error("request port open during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && ready) |=> !ready)
    else $error("second request taken while one is in progress");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_RESULT) |=> rsp.valid)
    else $error("result loaded but no response beat offered");

endmodule

`default_nettype wire

// ===== rtl/core/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer issuing datapath commands for allocate, split, merge and free.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [15:0] {
    ST_CLEAR    = 16'h0001,
    ST_IDLE     = 16'h0002,
    ST_DISPATCH = 16'h0004,
    ST_A_RD     = 16'h0008,
    ST_A_W1     = 16'h0010,
    ST_A_W2     = 16'h0020,
    ST_A_W3     = 16'h0040,
    ST_P_RD     = 16'h0080,
    ST_P_WR     = 16'h0100,
    ST_F_RD     = 16'h0200,
    ST_F_TST    = 16'h0400,
    ST_B_RD     = 16'h0800,
    ST_B_TST    = 16'h1000,
    ST_U2       = 16'h2000,
    ST_PU1      = 16'h4000,
    ST_PU2      = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   done_wait, done_wait_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      done_wait <= 1'b0;
    end else begin
      state     <= state_next;
      done_wait <= done_wait_next;
    end
  end

  // The result hand-over is a separate wait flag so that it can follow any
  // final step without an extra state per path.
  always_comb begin
    state_next     = state;
    done_wait_next = done_wait;
    cmd            = CMD_NOP;
    in_ready       = 1'b0;
    if (done_wait) begin
      if (!status.out_busy) begin
        cmd            = CMD_RESULT;
        done_wait_next = 1'b0;
        state_next     = ST_IDLE;
      end
    end else begin
      unique case (state)
        ST_CLEAR: begin
          cmd = CMD_CLEAR;
          if (status.clr_last) state_next = ST_IDLE;
        end
        ST_IDLE: begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd        = CMD_LOAD;
            state_next = ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (status.is_free)         state_next = ST_F_RD;
          else if (status.alloc_fail) done_wait_next = 1'b1;
          else if (status.e_eq_k)     state_next = ST_P_RD;
          else                        state_next = ST_A_RD;
        end
        ST_A_RD: begin
          cmd        = CMD_SPLIT_RD;
          state_next = ST_A_W1;
        end
        ST_A_W1: begin
          cmd        = CMD_SPLIT_W1;
          state_next = ST_A_W2;
        end
        ST_A_W2: begin
          cmd        = CMD_SPLIT_W2;
          state_next = ST_A_W3;
        end
        ST_A_W3: begin
          cmd        = CMD_SPLIT_W3;
          state_next = status.e_next_k ? ST_P_RD : ST_A_RD;
        end
        ST_P_RD: begin
          cmd        = CMD_POP_RD;
          state_next = ST_P_WR;
        end
        ST_P_WR: begin
          cmd            = CMD_POP_WR;
          done_wait_next = 1'b1;
        end
        ST_F_RD: begin
          cmd        = CMD_FREE_RD;
          state_next = ST_F_TST;
        end
        ST_F_TST: begin
          cmd = CMD_FREE_TST;
          if (status.free_bad)      done_wait_next = 1'b1;
          else if (status.free_top) state_next = ST_PU1;
          else                      state_next = ST_B_RD;
        end
        ST_B_RD: begin
          cmd        = CMD_BUD_RD;
          state_next = ST_B_TST;
        end
        ST_B_TST: begin
          if (status.bud_ok) begin
            cmd        = CMD_UNLINK;
            state_next = ST_U2;
          end else begin
            state_next = ST_PU1;
          end
        end
        ST_U2: begin
          cmd        = CMD_MERGE_W2;
          state_next = status.o_next_top ? ST_PU1 : ST_B_RD;
        end
        ST_PU1: begin
          cmd        = CMD_PUSH1;
          state_next = ST_PU2;
        end
        ST_PU2: begin
          cmd            = CMD_PUSH2;
          done_wait_next = 1'b1;
        end
        default: state_next = ST_CLEAR;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bfa_dp.sv =====
// ----------------------------------------------------------------------------
// bfa_dp
// Frame tables, free list heads and result register of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_dp
  import bfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  req_t       req_data,
  output rsp_t       rsp_data,
  output logic       rsp_valid,
  input  logic       rsp_ready
);

  logic [ORD_W-1:0]  order_mem [NFRAMES];
  logic              free_mem  [NFRAMES];
  logic [LINK_W-1:0] next_mem  [NFRAMES];
  logic [LINK_W-1:0] prev_mem  [NFRAMES];
  logic [LINK_W-1:0] head      [MAX_ORDER+1];

  logic [ORD_W-1:0]   order_rd;
  logic               free_rd;
  logic [LINK_W-1:0]  next_rd, prev_rd;
  logic [FRAME_W-1:0] rd_addr;

  logic               o_we, f_we, n_we, p_we;
  logic [FRAME_W-1:0] o_addr, f_addr, n_addr, p_addr;
  logic [ORD_W-1:0]   o_wd;
  logic               f_wd;
  logic [LINK_W-1:0]  n_wd, p_wd;

  logic               is_free_op, fail_q, res_ok;
  logic [ORD_W-1:0]   k, e, o;
  logic [FRAME_W-1:0] fi, a_q, idx, bd, res_blk, clr_cnt;
  logic [LINK_W-1:0]  h_q;

  logic [ORD_W-1:0]   c, t;
  logic               found;
  logic [FRAME_W-1:0] b_idx, bd_calc, lo, hi;

  assign c       = e - ORD_W'(1);
  assign b_idx   = a_q | (FRAME_W'(1) << c);
  assign bd_calc = idx ^ (FRAME_W'(1) << o);
  assign lo      = (idx < bd) ? idx : bd;
  assign hi      = (idx < bd) ? bd : idx;

  // Smallest non-empty list at or above the requested order.
  always_comb begin
    found = 1'b0;
    t     = '0;
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if (ORD_W'(i) >= req_data.order && !head[i][LINK_W-1]) begin
        found = 1'b1;
        t     = ORD_W'(i);
      end
    end
  end

  always_comb begin
    o_we = 1'b0; o_addr = '0; o_wd = ORD_NONE;
    f_we = 1'b0; f_addr = '0; f_wd = 1'b0;
    n_we = 1'b0; n_addr = '0; n_wd = NIL;
    p_we = 1'b0; p_addr = '0; p_wd = NIL;
    rd_addr = '0;
    case (cmd)
      CMD_CLEAR: begin
        o_we = 1'b1; o_addr = clr_cnt;
        o_wd = (clr_cnt == '0) ? ORD_MAX : ORD_NONE;
        f_we = 1'b1; f_addr = clr_cnt; f_wd = (clr_cnt == '0);
        n_we = 1'b1; n_addr = clr_cnt;
        p_we = 1'b1; p_addr = clr_cnt;
      end
      CMD_SPLIT_RD: rd_addr = head[e][FRAME_W-1:0];
      CMD_SPLIT_W1: begin
        p_we = !next_rd[LINK_W-1]; p_addr = next_rd[FRAME_W-1:0];
        n_we = 1'b1; n_addr = a_q;
        f_we = 1'b1; f_addr = a_q; f_wd = 1'b1;
        o_we = 1'b1; o_addr = a_q; o_wd = c;
      end
      CMD_SPLIT_W2: begin
        p_we = 1'b1; p_addr = a_q; p_wd = {1'b0, b_idx};
        n_we = 1'b1; n_addr = b_idx; n_wd = {1'b0, a_q};
        f_we = 1'b1; f_addr = b_idx; f_wd = 1'b1;
        o_we = 1'b1; o_addr = b_idx; o_wd = c;
      end
      CMD_SPLIT_W3: begin
        p_we = 1'b1; p_addr = b_idx;
      end
      CMD_POP_RD: rd_addr = head[k][FRAME_W-1:0];
      CMD_POP_WR: begin
        p_we = !next_rd[LINK_W-1]; p_addr = next_rd[FRAME_W-1:0];
        f_we = 1'b1; f_addr = a_q;
      end
      CMD_FREE_RD: rd_addr = fi;
      CMD_BUD_RD:  rd_addr = bd_calc;
      CMD_UNLINK: begin
        n_we = !prev_rd[LINK_W-1]; n_addr = prev_rd[FRAME_W-1:0]; n_wd = next_rd;
        p_we = !next_rd[LINK_W-1]; p_addr = next_rd[FRAME_W-1:0]; p_wd = prev_rd;
        f_we = 1'b1; f_addr = bd;
        o_we = 1'b1; o_addr = hi;
      end
      CMD_MERGE_W2: begin
        o_we = 1'b1; o_addr = lo; o_wd = o + ORD_W'(1);
      end
      CMD_PUSH1: begin
        n_we = 1'b1; n_addr = idx; n_wd = head[o];
        p_we = 1'b1; p_addr = idx;
        f_we = 1'b1; f_addr = idx; f_wd = 1'b1;
      end
      CMD_PUSH2: begin
        p_we = !h_q[LINK_W-1]; p_addr = h_q[FRAME_W-1:0]; p_wd = {1'b0, idx};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (o_we) order_mem[o_addr] <= o_wd;
    if (f_we) free_mem[f_addr]  <= f_wd;
    if (n_we) next_mem[n_addr]  <= n_wd;
    if (p_we) prev_mem[p_addr]  <= p_wd;
    order_rd <= order_mem[rd_addr];
    free_rd  <= free_mem[rd_addr];
    next_rd  <= next_mem[rd_addr];
    prev_rd  <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        head[i] <= (i == MAX_ORDER) ? '0 : NIL;
      end
      clr_cnt <= '0;
    end else begin
      case (cmd)
        CMD_CLEAR:    clr_cnt <= clr_cnt + FRAME_W'(1);
        CMD_SPLIT_W1: head[e] <= next_rd;
        CMD_SPLIT_W2: head[c] <= {1'b0, b_idx};
        CMD_POP_WR:   head[k] <= next_rd;
        CMD_UNLINK:   if (prev_rd[LINK_W-1]) head[o] <= next_rd;
        CMD_PUSH1:    head[o] <= {1'b0, idx};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        is_free_op <= req_data.operation;
        k          <= req_data.order;
        fi         <= req_data.frame_index;
        e          <= t;
        fail_q     <= (req_data.order >= ORD_MAX) || !found;
        res_ok     <= 1'b0;
        res_blk    <= '0;
      end
      CMD_SPLIT_RD: a_q <= head[e][FRAME_W-1:0];
      CMD_SPLIT_W3: e   <= c;
      CMD_POP_RD:   a_q <= head[k][FRAME_W-1:0];
      CMD_POP_WR: begin
        res_ok  <= 1'b1;
        res_blk <= a_q;
      end
      CMD_FREE_RD:  idx <= fi;
      CMD_FREE_TST: o   <= order_rd;
      CMD_BUD_RD:   bd  <= bd_calc;
      CMD_MERGE_W2: begin
        idx <= lo;
        o   <= o + ORD_W'(1);
      end
      CMD_PUSH1: h_q    <= head[o];
      CMD_PUSH2: res_ok <= 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd == CMD_RESULT) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_RESULT) begin
      rsp_data.ok          <= res_ok;
      rsp_data.block_index <= res_blk;
    end
  end

  always_comb begin
    status.clr_last   = &clr_cnt;
    status.is_free    = (is_free_op == OP_FREE);
    status.alloc_fail = fail_q;
    status.e_eq_k     = (e == k);
    status.e_next_k   = (e == k + ORD_W'(1));
    status.free_bad   = (order_rd > ORD_MAX) || free_rd;
    status.free_top   = (order_rd == ORD_MAX);
    status.bud_ok     = free_rd && (order_rd == o);
    status.o_next_top = (o == ORD_MAX - ORD_W'(1));
    status.out_busy   = rsp_valid && !rsp_ready;
  end

endmodule

`default_nettype wire

// ===== tb/sv/buddy_frame_allocator_test.sv =====
// ----------------------------------------------------------------------------
// buddy_frame_allocator_test
// Drives allocate and free requests into the buddy frame allocator and
// checks every response against a typed-in value or a behavioural model of the free lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module buddy_frame_allocator_test;
  import bfa_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bfa_chan_if #(.T(req_t)) req ();
  bfa_chan_if #(.T(rsp_t)) rsp ();

  buddy_frame_allocator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // Model of the allocator state.
  logic [ORD_W-1:0]  m_order [NFRAMES];
  logic              m_free  [NFRAMES];
  logic [LINK_W-1:0] m_next  [NFRAMES];
  logic [LINK_W-1:0] m_prev  [NFRAMES];
  logic [LINK_W-1:0] m_head  [MAX_ORDER+1];

  rsp_t pending_rsp [$];
  int   fail_count = 0;
  int   idle_cycles = 0;
  bit   stim_done = 1'b0;
  bit   hold_off = 1'b0;
  int   held_blocks [$];

  function automatic void push_free(int f, int o);
    logic [LINK_W-1:0] h;
    h = m_head[o];
    m_next[f] = h;
    m_prev[f] = NIL;
    if (!h[LINK_W-1]) m_prev[h[FRAME_W-1:0]] = LINK_W'(f);
    m_head[o] = LINK_W'(f);
    m_free[f] = 1'b1;
  endfunction

  function automatic void unlink_free(int f, int o);
    logic [LINK_W-1:0] n;
    logic [LINK_W-1:0] p;
    n = m_next[f];
    p = m_prev[f];
    if (!p[LINK_W-1]) m_next[p[FRAME_W-1:0]] = n;
    else m_head[o] = n;
    if (!n[LINK_W-1]) m_prev[n[FRAME_W-1:0]] = p;
    m_next[f] = NIL;
    m_prev[f] = NIL;
    m_free[f] = 1'b0;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < NFRAMES; i++) begin
      m_order[i] = ORD_NONE;
      m_free[i] = 1'b0;
      m_next[i] = NIL;
      m_prev[i] = NIL;
    end
    for (int i = 0; i <= MAX_ORDER; i++) m_head[i] = NIL;
    m_order[0] = ORD_MAX;
    push_free(0, MAX_ORDER);
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t res;
    int t, a, b, f, idx, o, bd;
    res = '0;
    if (r.operation == OP_ALLOC) begin
      if (r.order < MAX_ORDER) begin
        t = r.order;
        while (t <= MAX_ORDER && m_head[t][LINK_W-1]) t++;
        if (t <= MAX_ORDER) begin
          for (int e = t; e > r.order; e--) begin
            a = m_head[e][FRAME_W-1:0];
            unlink_free(a, e);
            b = a + (1 << (e - 1));
            m_order[a] = ORD_W'(e - 1);
            m_order[b] = ORD_W'(e - 1);
            push_free(a, e - 1);
            push_free(b, e - 1);
          end
          f = m_head[r.order][FRAME_W-1:0];
          unlink_free(f, r.order);
          res.ok = 1'b1;
          res.block_index = FRAME_W'(f);
        end
      end
    end else if (m_order[r.frame_index] <= ORD_MAX && !m_free[r.frame_index]) begin
      idx = r.frame_index;
      forever begin
        o = m_order[idx];
        if (o >= MAX_ORDER) begin
          push_free(idx, o);
          break;
        end
        bd = idx ^ (1 << o);
        if (!m_free[bd] || m_order[bd] != o) begin
          push_free(idx, o);
          break;
        end
        unlink_free(bd, o);
        m_order[idx > bd ? idx : bd] = ORD_NONE;
        idx = idx < bd ? idx : bd;
        m_order[idx] = ORD_W'(o + 1);
      end
      res.ok = 1'b1;
    end
    return res;
  endfunction

  // Directed table: exp_given marks rows whose response is typed in.
  typedef struct {
    req_t r;
    bit   exp_given;
    rsp_t e;
  } stim_row_t;

  stim_row_t stim_rows [$];
  req_t      rand_reqs [$];

  function automatic stim_row_t row(logic op, int ord, int fi, bit g, bit ok, int bi);
    stim_row_t s;
    s.r.operation = op;
    s.r.order = ORD_W'(ord);
    s.r.frame_index = FRAME_W'(fi);
    s.exp_given = g;
    s.e.ok = ok;
    s.e.block_index = FRAME_W'(bi);
    return s;
  endfunction

  initial begin
    stim_rows.push_back(row(OP_FREE,  0, 0,    1, 0, 0));   // whole memory is free
    stim_rows.push_back(row(OP_ALLOC, 10, 0,   1, 0, 0));   // order too large
    stim_rows.push_back(row(OP_ALLOC, 15, 1023, 1, 0, 0));
    stim_rows.push_back(row(OP_ALLOC, 0, 0,    1, 1, 512 + 256 + 128 + 64 + 32 + 16 + 8 + 4 + 2 + 1));
    stim_rows.push_back(row(OP_FREE,  0, 5,    1, 0, 0));   // not a block head
    stim_rows.push_back(row(OP_FREE,  0, 1023, 1, 1, 0));   // merges back to the top
    stim_rows.push_back(row(OP_FREE,  0, 1023, 1, 0, 0));   // already free
    stim_rows.push_back(row(OP_ALLOC, 9, 0,    1, 1, 512));
    stim_rows.push_back(row(OP_ALLOC, 9, 0,    1, 1, 0));
    stim_rows.push_back(row(OP_ALLOC, 0, 0,    1, 0, 0));   // nothing left
    stim_rows.push_back(row(OP_FREE,  0, 512,  0, 0, 0));
    stim_rows.push_back(row(OP_ALLOC, 3, 0,    0, 0, 0));
    stim_rows.push_back(row(OP_FREE,  0, 0,    0, 0, 0));
    stim_rows.push_back(row(OP_ALLOC, 5, 0,    0, 0, 0));
    stim_rows.push_back(row(OP_FREE,  0, 544,  0, 0, 0));
    stim_rows.push_back(row(OP_FREE,  0, 512,  0, 0, 0));
    stim_rows.push_back(row(OP_ALLOC, 8, 0,    0, 0, 0));
    stim_rows.push_back(row(OP_FREE,  0, 768,  0, 0, 0));
    stim_rows.push_back(row(OP_FREE,  0, 0,    0, 0, 0));
  end

  // Random request: half allocates, most of the rest frees of blocks handed out, the rest noise.
  function automatic req_t random_req();
    req_t r;
    int sel;
    r.operation = 1'($urandom);
    r.order = 4'($urandom);
    r.frame_index = 10'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      r.operation = OP_ALLOC;
      r.order = ORD_W'($urandom_range(0, sel == 0 ? 9 : 4));
    end else if (sel < 9 && held_blocks.size() > 0) begin
      int j;
      j = $urandom_range(0, held_blocks.size() - 1);
      r.operation = OP_FREE;
      r.frame_index = FRAME_W'(held_blocks[j]);
      held_blocks.delete(j);
    end
    return r;
  endfunction

  task automatic send_req(stim_row_t s);
    rsp_t p;
    req.valid <= 1'b1;
    req.data <= s.r;
    do @(posedge clk); while (!req.ready);
    p = predict_rsp(s.r);
    if (s.exp_given && p != s.e)
      $error("model disagrees with table: ok %0d/%0d block_index %0d/%0d",
             s.e.ok, p.ok, s.e.block_index, p.block_index);
    if (s.r.operation == OP_ALLOC && p.ok) held_blocks.push_back(p.block_index);
    pending_rsp.push_back(s.exp_given ? s.e : p);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Sender.
  initial begin
    stim_row_t s;
    req.valid = 1'b0;
    req.data = '0;
    reset_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (stim_rows[i]) send_req(stim_rows[i]);
    for (int n = 0; n < 700; n++) begin
      s.r = random_req();
      s.exp_given = 1'b0;
      s.e = '0;
      if (n == 300) hold_off <= 1'b1;
      send_req(s);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver with a stall pattern and one long hold-off.
  initial begin
    int phase;
    bit held_done;
    rsp.ready = 1'b0;
    phase = 0;
    held_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && !held_done) begin
        rsp.ready <= 1'b0;
        repeat (400) @(negedge clk);
        held_done = 1'b1;
      end
      phase++;
      rsp.ready <= (phase % 64 < 20) ? 1'b1 : (((phase * 7) % 5) != 0);
    end
  end

  // Response checker and watchdog.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          $error("response beat with nothing expected");
          fail_count++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.data.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, rsp.data.ok);
            fail_count++;
          end
          if (rsp.data.block_index !== want.block_index) begin
            $error("block_index: expected %0d, got %0d",
                   want.block_index, rsp.data.block_index);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_rsp.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/bfa_pkg.sv
rtl/core/bfa_chan_if.sv
rtl/core/bfa_ctrl.sv
rtl/core/bfa_dp.sv
rtl/core/buddy_frame_allocator.sv
tb/sv/buddy_frame_allocator_test.sv
